[src/c6502_pkg.sv]
// Package with the shared types and constants of the 6502 execute unit.
package c6502_pkg;

  typedef enum logic [5:0] {
    F_BRK = 6'd0,  F_ORA = 6'd1,  F_ASL = 6'd2,  F_BPL = 6'd3,  F_CLC = 6'd4,
    F_JSR = 6'd5,  F_BIT = 6'd6,  F_ROL = 6'd7,  F_PLP = 6'd8,  F_BMI = 6'd9,
    F_SEC = 6'd10, F_RTI = 6'd11, F_EOR = 6'd12, F_LSR = 6'd13, F_PHA = 6'd14,
    F_JMP = 6'd15, F_BVC = 6'd16, F_CLI = 6'd17, F_RTS = 6'd18, F_ADC = 6'd19,
    F_ROR = 6'd20, F_PLA = 6'd21, F_BVS = 6'd22, F_SEI = 6'd23, F_STA = 6'd24,
    F_STY = 6'd25, F_STX = 6'd26, F_DEY = 6'd27, F_TXA = 6'd28, F_BCC = 6'd29,
    F_TYA = 6'd30, F_TXS = 6'd31, F_TAY = 6'd32, F_TAX = 6'd33, F_LDA = 6'd34,
    F_LDX = 6'd35, F_LDY = 6'd36, F_BCS = 6'd37, F_CLV = 6'd38, F_TSX = 6'd39,
    F_CPY = 6'd40, F_CMP = 6'd41, F_DEC = 6'd42, F_CLD = 6'd43, F_CPX = 6'd44,
    F_SBC = 6'd45, F_INC = 6'd46, F_INX = 6'd47, F_NOP = 6'd48, F_BEQ = 6'd49,
    F_SED = 6'd50, F_DEX = 6'd51, F_AND = 6'd52, F_PHP = 6'd53, F_INY = 6'd54,
    F_BNE = 6'd55
  } func_t;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [1:0]  IDX_X = 2'd1;
  localparam logic [1:0]  IDX_Y = 2'd2;

  localparam logic [7:0]  SP_RESET       = 8'hFD;
  localparam logic [7:0]  P_RESET        = 8'h24;
  localparam logic [15:0] START_PC_RESET = 16'h8000;
  localparam int          STACK_BASE_DEF = 256;

  localparam logic        REG_START_PC   = 1'b0;

endpackage

[src/cpu6502_execute_unit.sv]
// Top level of the 6502 execute unit: register file, banked stack page and result stage.
//
// channel  direction  handshake                         contents
// s_*      in         s_tvalid / s_tready               one decoded instruction word
// m_*      out        m_tvalid / m_tready               register file, cycles, external write
// apb      in/out     psel & penable & pwrite & pready  start_pc at byte address 0
//
// The accept edge issues the stack page reads (both banks, two read ports each);
// the retire edge executes the instruction against the registered read data and
// retires it into the result register. The next word is accepted as soon as the
// execute stage is empty, even while a finished result waits in the output
// register, so a word is never taken while the last one is still executing.
// A full output register that is not taken holds the execute stage.
// Reset is synchronous: the register file takes its reset values, the program
// counter takes start_pc and the 256 stack page valid bits clear.
module cpu6502_execute_unit
  import c6502_pkg::*;
#(
  parameter int STACK_BASE = STACK_BASE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: func[5:0], uses_memory[6], index_source[8:7],
  // indexed_mode[9], address[25:10], operand_data[33:26], base_cycles[36:34],
  // instr_size[38:37], zero fill [39].
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: pc_out[15:0], acc_out[23:16], x_out[31:24], y_out[39:32],
  // sp_out[47:40], status_out[55:48], cycles_taken[59:56], write_enable[60],
  // write_address[76:61], write_data[84:77], zero fill [87:85].
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [15:0] SBASE = STACK_BASE[15:0];

  // Architectural state.
  logic [7:0]  acc, xr, yr, sp, pf;
  logic [15:0] pc, start_pc;

  // Execute stage: the accepted word plus the registered read data.
  logic        ex_valid;
  logic [5:0]  ex_func;
  logic        ex_mem;
  logic [1:0]  ex_isel;
  logic        ex_imode;
  logic [15:0] ex_addr;
  logic [7:0]  ex_data;
  logic [2:0]  ex_cyc;
  logic [1:0]  ex_size;

  // Stack page, split by address parity so that two neighboring entries can be
  // written, and three read, in one cycle.
  logic [7:0]  bank0 [128];
  logic [7:0]  bank1 [128];
  logic [255:0] vld;
  logic [7:0]  b0_ra, b0_rb, b1_ra, b1_rb;
  logic        v0, v1, v2, a0_par, a1_par;

  logic        out_valid;
  logic [87:0] out_data;

  // Accept side.
  logic        accept, retire;
  logic [5:0]  in_func;
  logic [15:0] in_soff;
  logic        in_pull;
  logic [7:0]  ra0, ra1, ra2;
  logic [6:0]  b0_aa, b1_aa;

  assign s_tready = !ex_valid;
  assign accept   = s_tvalid && s_tready;
  assign retire   = ex_valid && (!out_valid || m_tready);

  assign in_func  = s_tdata[5:0];
  assign in_soff  = s_tdata[25:10] - SBASE;
  assign in_pull  = (in_func == F_PLA) || (in_func == F_PLP) ||
                    (in_func == F_RTS) || (in_func == F_RTI);
  assign ra0      = in_pull ? sp + 8'd1 : in_soff[7:0];
  assign ra1      = sp + 8'd2;
  assign ra2      = sp + 8'd3;
  assign b0_aa    = ra1[0] ? ra2[7:1] : ra1[7:1];
  assign b1_aa    = ra1[0] ? ra1[7:1] : ra2[7:1];

  // Execute side signals.
  logic [7:0]  d0, d1, d2, opnd, ival, sv, mv, m_add;
  logic [15:0] nxt, soff, tgt, ret;
  logic        in_stack, rpen, cond, mw_en;
  logic [8:0]  sum;
  logic [7:0]  acc_next, x_next, y_next, sp_next, p_next;
  logic [15:0] pc_next, wa;
  logic [3:0]  cyc;
  logic        we;
  logic [7:0]  wd;
  logic        w0_en, w1_en;
  logic [7:0]  w0_a, w1_a, w0_d, w1_d;

  assign d0 = (a0_par ? b1_rb : b0_rb) & {8{v0}};
  assign d1 = (a1_par ? b1_ra : b0_ra) & {8{v1}};
  assign d2 = (a1_par ? b0_ra : b1_ra) & {8{v2}};

  assign nxt      = pc + {14'd0, ex_size};
  assign soff     = ex_addr - SBASE;
  assign in_stack = soff[15:8] == 8'd0;
  assign opnd     = (ex_mem && in_stack) ? d0 : ex_data;
  assign ival     = (ex_isel == IDX_X) ? xr : ((ex_isel == IDX_Y) ? yr : 8'd0);
  assign rpen     = ex_mem && ex_imode &&
                    ((ex_addr - {8'd0, ival}) >> 8) != (ex_addr >> 8);
  assign sv       = ex_mem ? opnd : acc;
  assign m_add    = (ex_func == F_SBC) ? ~opnd : opnd;
  assign sum      = {1'b0, acc} + {1'b0, m_add} + {8'd0, pf[FL_C]};
  assign tgt      = nxt + {{8{ex_data[7]}}, ex_data};
  assign ret      = nxt - 16'd1;

  always_comb begin
    acc_next = acc;
    x_next   = xr;
    y_next   = yr;
    sp_next  = sp;
    p_next   = pf;
    pc_next  = nxt;
    cyc      = {1'b0, ex_cyc};
    cond     = 1'b0;
    mw_en    = 1'b0;
    mv       = 8'd0;
    w0_en    = 1'b0;
    w0_a     = sp;
    w0_d     = 8'd0;
    w1_en    = 1'b0;
    w1_a     = sp - 8'd1;
    w1_d     = 8'd0;
    we       = 1'b0;
    wa       = 16'd0;
    wd       = 8'd0;
    unique case (func_t'(ex_func))
      F_ORA: begin acc_next = acc | opnd; cyc = cyc + {3'd0, rpen}; end
      F_EOR: begin acc_next = acc ^ opnd; cyc = cyc + {3'd0, rpen}; end
      F_AND: begin acc_next = acc & opnd; cyc = cyc + {3'd0, rpen}; end
      F_ADC, F_SBC: begin
        acc_next      = sum[7:0];
        p_next[FL_C]  = sum[8];
        p_next[FL_V]  = (m_add[7] ^ sum[7]) & (acc[7] ^ sum[7]);
        cyc           = cyc + {3'd0, rpen};
      end
      F_CMP: begin
        p_next[FL_C] = acc >= opnd;
        mv           = acc - opnd;
        cyc          = cyc + {3'd0, rpen};
      end
      F_CPX: begin p_next[FL_C] = xr >= opnd; mv = xr - opnd; end
      F_CPY: begin p_next[FL_C] = yr >= opnd; mv = yr - opnd; end
      F_LDA: begin acc_next = opnd; cyc = cyc + {3'd0, rpen}; end
      F_LDX: begin x_next = opnd; cyc = cyc + {3'd0, rpen}; end
      F_LDY: begin y_next = opnd; cyc = cyc + {3'd0, rpen}; end
      F_ASL: begin p_next[FL_C] = sv[7]; mv = {sv[6:0], 1'b0}; end
      F_ROL: begin p_next[FL_C] = sv[7]; mv = {sv[6:0], pf[FL_C]}; end
      F_LSR: begin p_next[FL_C] = sv[0]; mv = {1'b0, sv[7:1]}; end
      F_ROR: begin p_next[FL_C] = sv[0]; mv = {pf[FL_C], sv[7:1]}; end
      F_DEC: begin mv = opnd - 8'd1; mw_en = 1'b1; end
      F_INC: begin mv = opnd + 8'd1; mw_en = 1'b1; end
      F_STA: begin mv = acc; mw_en = 1'b1; end
      F_STY: begin mv = yr; mw_en = 1'b1; end
      F_STX: begin mv = xr; mw_en = 1'b1; end
      F_BIT: begin
        p_next[FL_Z] = (acc & opnd) == 8'd0;
        p_next[FL_V] = opnd[6];
        p_next[FL_N] = opnd[7];
      end
      F_CLC: p_next[FL_C] = 1'b0;
      F_SEC: p_next[FL_C] = 1'b1;
      F_CLI: p_next[FL_I] = 1'b0;
      F_SEI: p_next[FL_I] = 1'b1;
      F_CLV: p_next[FL_V] = 1'b0;
      F_CLD: p_next[FL_D] = 1'b0;
      F_SED: p_next[FL_D] = 1'b1;
      F_DEY: y_next = yr - 8'd1;
      F_INY: y_next = yr + 8'd1;
      F_DEX: x_next = xr - 8'd1;
      F_INX: x_next = xr + 8'd1;
      F_TXA: acc_next = xr;
      F_TYA: acc_next = yr;
      F_TAY: y_next = acc;
      F_TAX: x_next = acc;
      F_TXS: sp_next = xr;
      F_TSX: x_next = sp;
      F_PHA: begin w0_en = 1'b1; w0_d = acc; sp_next = sp - 8'd1; end
      F_PHP: begin
        w0_en   = 1'b1;
        w0_d    = pf | 8'h30;
        sp_next = sp - 8'd1;
      end
      F_PLA: begin acc_next = d0; sp_next = sp + 8'd1; end
      F_PLP: begin p_next = (d0 & 8'hEF) | 8'h20; sp_next = sp + 8'd1; end
      F_JMP: pc_next = ex_addr;
      F_JSR: begin
        w0_en   = 1'b1;
        w0_d    = ret[15:8];
        w1_en   = 1'b1;
        w1_d    = ret[7:0];
        sp_next = sp - 8'd2;
        pc_next = ex_addr;
      end
      F_RTS: begin pc_next = {d1, d0} + 16'd1; sp_next = sp + 8'd2; end
      F_RTI: begin
        p_next  = (d0 & 8'hEF) | 8'h20;
        pc_next = {d2, d1};
        sp_next = sp + 8'd3;
      end
      F_BPL: cond = !pf[FL_N];
      F_BMI: cond = pf[FL_N];
      F_BVC: cond = !pf[FL_V];
      F_BVS: cond = pf[FL_V];
      F_BCC: cond = !pf[FL_C];
      F_BCS: cond = pf[FL_C];
      F_BNE: cond = !pf[FL_Z];
      F_BEQ: cond = pf[FL_Z];
      default: ;
    endcase

    // Flags N and Z follow the value that the instruction produced.
    case (func_t'(ex_func))
      F_ORA, F_EOR, F_AND, F_ADC, F_SBC, F_LDA, F_PLA, F_TXA, F_TYA: begin
        p_next[FL_Z] = acc_next == 8'd0;
        p_next[FL_N] = acc_next[7];
      end
      F_LDX, F_DEX, F_INX, F_TAX, F_TSX: begin
        p_next[FL_Z] = x_next == 8'd0;
        p_next[FL_N] = x_next[7];
      end
      F_LDY, F_DEY, F_INY, F_TAY: begin
        p_next[FL_Z] = y_next == 8'd0;
        p_next[FL_N] = y_next[7];
      end
      F_CMP, F_CPX, F_CPY, F_DEC, F_INC, F_ASL, F_ROL, F_LSR, F_ROR: begin
        p_next[FL_Z] = mv == 8'd0;
        p_next[FL_N] = mv[7];
      end
      default: ;
    endcase

    // Shifts go back to memory or to the accumulator.
    if ((ex_func == F_ASL) || (ex_func == F_ROL) || (ex_func == F_LSR) ||
        (ex_func == F_ROR)) begin
      if (ex_mem) begin
        mw_en = 1'b1;
      end else begin
        acc_next = mv;
      end
    end

    // A memory write lands in the stack page or leaves the block.
    if (mw_en) begin
      if (in_stack) begin
        w0_en = 1'b1;
        w0_a  = soff[7:0];
        w0_d  = mv;
      end else begin
        we = 1'b1;
        wa = ex_addr;
        wd = mv;
      end
    end

    // A taken branch increments the reported cycle count, and again when it leaves the page.
    if (cond) begin
      pc_next = tgt;
      cyc     = cyc + 4'd1 + {3'd0, tgt[15:8] != nxt[15:8]};
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_PC) ? {16'd0, start_pc} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= START_PC_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_START_PC) begin
      start_pc <= pwdata[15:0];
    end
  end

  // Register file and pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'd0;
      xr        <= 8'd0;
      yr        <= 8'd0;
      sp        <= SP_RESET;
      pf        <= P_RESET;
      pc        <= start_pc;
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (retire) begin
        ex_valid <= 1'b0;
      end
      if (retire) begin
        acc       <= acc_next;
        xr        <= x_next;
        yr        <= y_next;
        sp        <= sp_next;
        pf        <= p_next;
        pc        <= pc_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_func  <= s_tdata[5:0];
      ex_mem   <= s_tdata[6];
      ex_isel  <= s_tdata[8:7];
      ex_imode <= s_tdata[9];
      ex_addr  <= s_tdata[25:10];
      ex_data  <= s_tdata[33:26];
      ex_cyc   <= s_tdata[36:34];
      ex_size  <= s_tdata[38:37];
    end
    if (retire) begin
      out_data <= {3'd0, wd, wa, we, cyc, p_next, sp_next, y_next, x_next,
                   acc_next, pc_next};
    end
  end

  // Stack page reads, issued at the accept edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      b0_ra  <= bank0[b0_aa];
      b1_ra  <= bank1[b1_aa];
      b0_rb  <= bank0[ra0[7:1]];
      b1_rb  <= bank1[ra0[7:1]];
      v0     <= vld[ra0];
      v1     <= vld[ra1];
      v2     <= vld[ra2];
      a0_par <= ra0[0];
      a1_par <= ra1[0];
    end
  end

  // Stack page writes at retire; the two writes always hit different banks.
  always_ff @(posedge clk) begin
    if (retire) begin
      if (w0_en && !w0_a[0]) begin
        bank0[w0_a[7:1]] <= w0_d;
      end else if (w1_en && !w1_a[0]) begin
        bank0[w1_a[7:1]] <= w1_d;
      end
      if (w0_en && w0_a[0]) begin
        bank1[w0_a[7:1]] <= w0_d;
      end else if (w1_en && w1_a[0]) begin
        bank1[w1_a[7:1]] <= w1_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (retire) begin
      vld <= vld | ({255'd0, w0_en} << w0_a) | ({255'd0, w1_en} << w1_a);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ex_valid)
    else $error("accepted word did not enter the execute stage");

  a_retire_out: assert property (@(posedge clk) disable iff (rst)
    ex_valid && !out_valid |=> out_valid && !ex_valid)
    else $error("execute stage did not retire into an empty output register");

  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    retire && w0_en && w1_en |-> w0_a[0] != w1_a[0])
    else $error("two stack writes hit the same bank");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(accept && retire))
    else $error("read issue overlapped a stack write");

endmodule
